// ===== hdl/lebc_pkg.sv =====
package lebc_pkg;

  // Buffer sizing.
  localparam int CAPACITY   = 128;
  localparam int LINE_MAX   = 100;
  localparam int LIMIT      = (CAPACITY < LINE_MAX) ? CAPACITY : LINE_MAX;

  // The ring of cells is padded up to whole 8-byte windows.
  localparam int LANES      = 8;
  localparam int NCELL      = ((LIMIT + LANES - 1) / LANES) * LANES;
  localparam int NWIN       = NCELL / LANES;
  localparam int POS_W      = $clog2(NCELL + 2);
  localparam int WIN_W      = $clog2(NWIN + 1);
  localparam int CHAR_W     = 7;

  // Printable range accepted by the type command.
  localparam logic [7:0] KEY_LO = 8'h20;
  localparam logic [7:0] KEY_HI = 8'h7E;

  // Field widths of the channels.
  localparam int FUNC_W     = 3;
  localparam int KEY_W      = 8;
  localparam int CHUNK_W    = 64;
  localparam int COUNT_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_HOME  = 3'd0,
    FN_END   = 3'd1,
    FN_LEFT  = 3'd2,
    FN_RIGHT = 3'd3,
    FN_TYPE  = 3'd4,
    FN_ERASE = 3'd5,
    FN_PRINT = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_e;

  // Command broadcast to every cell of the ring.
  typedef struct packed {
    cell_op_e           op;
    logic [CHAR_W-1:0]  key;
    logic [POS_W-1:0]   cursor;
  } cell_cmd_t;

  typedef struct packed {
    logic               ok;
    logic [CHUNK_W-1:0] text_chunk;
    logic [COUNT_W-1:0] chunk_count;
    logic               last;
  } result_t;

endpackage

// ===== hdl/lebc_if.sv =====
// Command channel.
interface lebc_cmd_if;
  import lebc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

// Result channel.
interface lebc_res_if;
  import lebc_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [CHUNK_W-1:0] text_chunk;
  logic [COUNT_W-1:0] chunk_count;
  logic               last;

  modport source (output valid, output ok, output text_chunk, output chunk_count,
                  output last, input ready);
  modport sink   (input valid, input ok, input text_chunk, input chunk_count,
                  input last, output ready);
endinterface

// ===== hdl/lebc_cell.sv =====
module lebc_cell
  import lebc_pkg::*;
(
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [POS_W-1:0]  index_i,
  input  logic [CHAR_W-1:0] left_i,
  input  logic [CHAR_W-1:0] right_i,
  input  logic [CHAR_W-1:0] rot_i,
  output logic [CHAR_W-1:0] char_o
);

  logic [CHAR_W-1:0] char_q;
  logic [CHAR_W-1:0] char_d;
  logic [POS_W:0]    index_inc;

  assign index_inc = {1'b0, index_i} + (POS_W+1)'(1);

  // Each cell decides from its own index where its next character comes from.
  always_comb begin
    char_d = char_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (index_i > cmd_i.cursor) begin
          char_d = left_i;
        end else if (index_i == cmd_i.cursor) begin
          char_d = cmd_i.key;
        end
      end
      CELL_DELETE: begin
        if (index_inc >= {1'b0, cmd_i.cursor}) begin
          char_d = right_i;
        end
      end
      CELL_ROTATE: char_d = rot_i;
      default:     char_d = char_q;
    endcase
  end

  // Character storage holds no reset value.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

// ===== hdl/lebc_out_fifo.sv =====
module lebc_out_fifo
  import lebc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       data_i,
  output logic          full_o,
  lebc_res_if.source    res_o
);

  result_t     ent_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [1:0]  cnt_d;
  logic        pop;
  result_t     head;

  assign pop    = res_o.valid && res_o.ready;
  assign full_o = (cnt_q == 2'd2);
  assign head   = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.ok          = head.ok;
  assign res_o.text_chunk  = head.text_chunk;
  assign res_o.chunk_count = head.chunk_count;
  assign res_o.last        = head.last;

endmodule

// ===== hdl/line_edit_buffer_with_cursor.sv =====
// Edits (home, end, left, right, type, erase) are applied at acceptance; the result
// item is pushed into the output queue, whose registered head feeds the result port.
// Print steps through each 8-character window of the 104-cell ring, which rotates
// fully back, emitting one chunk per window in use.
// A two-entry output queue keeps commands flowing while results wait.
// Reset clears length, cursor, state and queue; the characters are not reset.
module line_edit_buffer_with_cursor
  import lebc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lebc_cmd_if.sink    cmd_i,
  lebc_res_if.source  res_o
);

  state_e             state_q, state_d;
  logic [POS_W-1:0]   len_q, len_d;
  logic [POS_W-1:0]   cur_q, cur_d;
  logic [KEY_W-1:0]   sep_q, sep_d;
  logic [POS_W-1:0]   nbytes_q, nbytes_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [CHAR_W-1:0]  prev_q, prev_d;

  logic [CHAR_W-1:0]  cell_char [NCELL];
  cell_cmd_t          cell_cmd;
  logic               fifo_full;
  logic               push;
  result_t            push_data;
  logic               accept;
  logic               emitting;
  logic [POS_W+3:0]   win_base;
  logic [POS_W+3:0]   rem;
  logic [COUNT_W-1:0] count;
  logic [CHUNK_W-1:0] chunk;
  logic               key_ok;

  assign cmd_i.ready = (state_q == ST_IDLE) && !fifo_full;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign key_ok      = (cmd_i.key_code >= KEY_LO) && (cmd_i.key_code <= KEY_HI);

  // Print window arithmetic.
  assign win_base = (POS_W+4)'(win_q) << 3;
  assign rem      = (POS_W+4)'(nbytes_q) - win_base;
  assign emitting = (win_q == '0) || (win_base < (POS_W+4)'(nbytes_q));
  assign count    = (rem >= (POS_W+4)'(LANES)) ? COUNT_W'(LANES) : COUNT_W'(rem);

  // Lane formatting: the separator shifts later characters up by one lane.
  always_comb begin
    logic [POS_W+3:0] p;
    chunk = '0;
    for (int j = 0; j < LANES; j++) begin
      p = win_base + (POS_W+4)'(j);
      if (COUNT_W'(j) < count) begin
        if (sep_q != '0 && p == (POS_W+4)'(cur_q)) begin
          chunk[8*j +: 8] = sep_q;
        end else if (sep_q != '0 && p > (POS_W+4)'(cur_q)) begin
          chunk[8*j +: 8] = (j == 0) ? {1'b0, prev_q} : {1'b0, cell_char[(j == 0) ? 0 : j-1]};
        end else begin
          chunk[8*j +: 8] = {1'b0, cell_char[j]};
        end
      end
    end
  end

  // Command decode and print sequencing.
  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    cur_d         = cur_q;
    sep_d         = sep_q;
    nbytes_d      = nbytes_q;
    win_d         = win_q;
    prev_d        = prev_q;
    cell_cmd.op     = CELL_HOLD;
    cell_cmd.key    = cmd_i.key_code[CHAR_W-1:0];
    cell_cmd.cursor = cur_q;
    push          = 1'b0;
    push_data.ok          = 1'b1;
    push_data.text_chunk  = '0;
    push_data.chunk_count = '0;
    push_data.last        = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (cmd_i.func)
            FN_HOME:  cur_d = '0;
            FN_END:   cur_d = len_q;
            FN_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - POS_W'(1);
              end
            end
            FN_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + POS_W'(1);
              end
            end
            FN_TYPE: begin
              if (key_ok && len_q < POS_W'(LIMIT)) begin
                cell_cmd.op = CELL_INSERT;
                cur_d       = cur_q + POS_W'(1);
                len_d       = len_q + POS_W'(1);
              end else begin
                push_data.ok = 1'b0;
              end
            end
            FN_ERASE: begin
              if (cur_q != '0) begin
                cell_cmd.op = CELL_DELETE;
                cur_d       = cur_q - POS_W'(1);
                len_d       = len_q - POS_W'(1);
              end else begin
                push_data.ok = 1'b0;
              end
            end
            FN_PRINT: begin
              push     = 1'b0;
              sep_d    = cmd_i.key_code;
              nbytes_d = len_q + POS_W'(cmd_i.key_code != '0);
              win_d    = '0;
              state_d  = ST_PRINT;
            end
            default:  push_data.ok = 1'b0;
          endcase
        end
      end
      ST_PRINT: begin
        if (!emitting || !fifo_full) begin
          push                  = emitting;
          push_data.text_chunk  = chunk;
          push_data.chunk_count = count;
          push_data.last        = (rem <= (POS_W+4)'(LANES));
          cell_cmd.op           = CELL_ROTATE;
          prev_d                = cell_char[LANES-1];
          win_d                 = win_q + WIN_W'(1);
          if (win_q == WIN_W'(NWIN - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      win_q   <= win_d;
    end
  end

  // Print payload registers.
  always_ff @(posedge clk_i) begin
    sep_q    <= sep_d;
    nbytes_q <= nbytes_d;
    prev_q   <= prev_d;
  end

  // Ring of character cells; rotation moves whole 8-cell windows toward cell 0.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int ROT_SRC = (i + LANES) % NCELL;
    logic [CHAR_W-1:0] left_char;
    logic [CHAR_W-1:0] right_char;

    if (i == 0) begin : g_first
      assign left_char = '0;
    end else begin : g_inner_l
      assign left_char = cell_char[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign right_char = '0;
    end else begin : g_inner_r
      assign right_char = cell_char[i+1];
    end

    lebc_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .index_i (POS_W'(i)),
      .left_i  (left_char),
      .right_i (right_char),
      .rot_i   (cell_char[ROT_SRC]),
      .char_o  (cell_char[i])
    );
  end

  lebc_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (fifo_full),
    .res_o  (res_o)
  );

endmodule

// ===== tb/line_edit_buffer_with_cursor_tb.sv =====
`timescale 1ns / 100ps

module line_edit_buffer_with_cursor_tb;
  import lebc_pkg::*;

  // The one command code that the package leaves unnamed.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_e;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                typed;
    result_t           res;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  lebc_cmd_if cmd_bus ();
  lebc_res_if res_bus ();

  line_edit_buffer_with_cursor DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  // Shadow copy of the line and its cursor.
  logic [CHAR_W-1:0] line_chars [LIMIT];
  int unsigned       line_len;
  int unsigned       line_cur;

  result_t     chunk_q [$];
  int          err_cnt;
  int          items_sent;
  int          results_seen;
  int          full_hits;
  int          longest_print;
  int          cycle_cnt;
  int          stall_left;
  bit          quiet;
  cmd_row_t    dir_tab [$];

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cmd_row_t mk_row(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                                      input bit typed, input logic ok,
                                      input logic [CHUNK_W-1:0] chunk,
                                      input logic [COUNT_W-1:0] cnt);
    cmd_row_t row;
    row.func              = fn;
    row.key               = key;
    row.typed             = typed;
    row.res.ok            = ok;
    row.res.text_chunk    = chunk;
    row.res.chunk_count   = cnt;
    row.res.last          = 1'b1;
    return row;
  endfunction

  // Apply one accepted command to the shadow line and queue what it should produce.
  task automatic predict_line(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                              input bit typed, input result_t typed_res);
    result_t        produced [$];
    result_t        one;
    logic [7:0]     shown [$];
    int unsigned    i;
    int unsigned    j;
    int unsigned    n;
    int unsigned    cnt;
    one.ok          = 1'b1;
    one.text_chunk  = '0;
    one.chunk_count = '0;
    one.last        = 1'b1;
    case (fn)
      FN_HOME: line_cur = 0;
      FN_END: line_cur = line_len;
      FN_LEFT: begin
        if (line_cur > 0) line_cur--;
      end
      FN_RIGHT: begin
        if (line_cur < line_len) line_cur++;
      end
      FN_TYPE: begin
        if (key >= KEY_LO && key <= KEY_HI && line_len < LIMIT) begin
          for (i = line_len; i > line_cur; i--) line_chars[i] = line_chars[i-1];
          line_chars[line_cur] = key[CHAR_W-1:0];
          line_cur++;
          line_len++;
        end else begin
          one.ok = 1'b0;
          if (line_len == LIMIT) full_hits++;
        end
      end
      FN_ERASE: begin
        if (line_cur > 0) begin
          for (i = line_cur; i < line_len; i++) line_chars[i-1] = line_chars[i];
          line_cur--;
          line_len--;
        end else begin
          one.ok = 1'b0;
        end
      end
      FN_PRINT: begin
        // Build the printed text, with the separator slotted in at the cursor.
        for (i = 0; i <= line_len; i++) begin
          if (i == line_cur && key != 0) shown.push_back(key);
          if (i == line_len) break;
          shown.push_back({1'b0, line_chars[i]});
        end
        n = shown.size();
        for (i = 0; i < n; i += LANES) begin
          cnt             = (n - i < LANES) ? (n - i) : LANES;
          one.text_chunk  = '0;
          for (j = 0; j < cnt; j++) one.text_chunk[8*j +: 8] = shown[i+j];
          one.chunk_count = cnt[COUNT_W-1:0];
          one.last        = (i + cnt >= n);
          produced.push_back(one);
        end
      end
      default: one.ok = 1'b0;
    endcase
    // Everything but a nonempty print gives a single result.
    if (produced.size() == 0) produced.push_back(one);
    if (produced.size() > longest_print) longest_print = produced.size();
    if (typed) begin
      chunk_q.push_back(typed_res);
    end else begin
      foreach (produced[k]) chunk_q.push_back(produced[k]);
    end
  endtask

  // Offer one command, with an occasional gap before it, and wait for acceptance.
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                          input bit typed, input result_t typed_res);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= fn;
    cmd_bus.key_code <= key;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    items_sent++;
    predict_line(fn, key, typed, typed_res);
  endtask

  // Random commands, weighted toward filling, emptying, or a bit of everything.
  task automatic run_mix(input mix_e mix, input int count);
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0]  key;
    result_t           none;
    int                r;
    none = '0;
    repeat (count) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: begin
          fn = (r < 88) ? FN_TYPE : (r < 90) ? FN_LEFT : (r < 92) ? FN_RIGHT :
               (r < 93) ? FN_HOME : (r < 95) ? FN_END : (r < 98) ? FN_PRINT :
               (r < 99) ? FN_ERASE : FN_UNUSED;
        end
        MIX_DRAIN: begin
          fn = (r < 65) ? FN_ERASE : (r < 72) ? FN_END : (r < 78) ? FN_RIGHT :
               (r < 82) ? FN_LEFT : (r < 85) ? FN_HOME : (r < 93) ? FN_PRINT :
               (r < 98) ? FN_TYPE : FN_UNUSED;
        end
        default: begin
          fn = (r < 30) ? FN_TYPE : (r < 50) ? FN_ERASE : (r < 58) ? FN_LEFT :
               (r < 66) ? FN_RIGHT : (r < 71) ? FN_HOME : (r < 76) ? FN_END :
               (r < 95) ? FN_PRINT : FN_UNUSED;
        end
      endcase
      // Mostly printable keys for typing, frequent no-separator prints.
      r = $urandom_range(0, 99);
      if (fn == FN_TYPE && r < 90) key = KEY_W'($urandom_range(KEY_LO, KEY_HI));
      else if (fn == FN_PRINT && r < 40) key = '0;
      else key = KEY_W'($urandom_range(0, 255));
      send_cmd(fn, key, 1'b0, none);
    end
  endtask

  // Result side: check each accepted item, then pick the next ready level.
  initial begin
    result_t want;
    res_bus.ready = 1'b0;
    stall_left    = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (chunk_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result item ok=%0b chunk=%h count=%0d last=%0b", $time,
                   res_bus.ok, res_bus.text_chunk, res_bus.chunk_count, res_bus.last);
        end else begin
          want = chunk_q.pop_front();
          if (res_bus.ok !== want.ok) begin
            err_cnt++;
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, res_bus.ok);
          end
          if (res_bus.text_chunk !== want.text_chunk) begin
            err_cnt++;
            $display("%0t: text_chunk expected %h actual %h", $time, want.text_chunk,
                     res_bus.text_chunk);
          end
          if (res_bus.chunk_count !== want.chunk_count) begin
            err_cnt++;
            $display("%0t: chunk_count expected %0d actual %0d", $time, want.chunk_count,
                     res_bus.chunk_count);
          end
          if (res_bus.last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, res_bus.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt,
             chunk_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Command side: reset, directed table, then the random phases.
  initial begin
    err_cnt          = 0;
    items_sent       = 0;
    results_seen     = 0;
    full_hits        = 0;
    longest_print    = 0;
    quiet            = 1'b0;
    line_len         = 0;
    line_cur         = 0;
    rst_ni           = 1'b0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.func     = FN_HOME;
    cmd_bus.key_code = '0;

    dir_tab = '{
      // Empty line: prints with and without a separator.
      mk_row(FN_PRINT, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_PRINT, 8'h58, 1'b1, 1'b1, 64'h58, 4'd1),
      mk_row(FN_ERASE, 8'h00, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_LEFT, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_RIGHT, 8'hFF, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_UNUSED, 8'hA5, 1'b1, 1'b0, 64'h0, 4'd0),
      // Keys outside and at the edges of the printable range.
      mk_row(FN_TYPE, 8'h1F, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_TYPE, 8'h7F, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_TYPE, 8'h00, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_TYPE, 8'hFF, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_TYPE, KEY_LO, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_TYPE, KEY_HI, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_PRINT, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_HOME, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_ERASE, 8'h00, 1'b1, 1'b0, 64'h0, 4'd0),
      mk_row(FN_RIGHT, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_TYPE, 8'h41, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_PRINT, 8'hFF, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_END, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_RIGHT, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_ERASE, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_LEFT, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_PRINT, 8'h2D, 1'b0, 1'b0, 64'h0, 4'd0),
      mk_row(FN_HOME, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0),
      mk_row(FN_LEFT, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) send_cmd(dir_tab[r].func, dir_tab[r].key, dir_tab[r].typed,
                                  dir_tab[r].res);

    // Fill past the length limit, empty again, then a mixed phase at full rate.
    run_mix(MIX_FILL, 150);
    run_mix(MIX_DRAIN, 140);
    quiet = 1'b1;
    run_mix(MIX_ANY, 60);
    cmd_bus.valid <= 1'b0;

    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d result items.", items_sent, results_seen);
    $display("Typing hit a full line %0d times; longest print gave %0d chunks.", full_hits,
             longest_print);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
